@@ hw/rtl/fdzre_pkg.sv @@
// Shared types, constants and control codes for the frame delta zero-run encoder.
package fdzre_pkg;

  localparam int unsigned RUN_LIMIT_DEF       = 255;
  localparam int unsigned MAX_FRAME_BYTES_DEF = 16777216;
  localparam int unsigned BYTES_PER_RESULT    = 8;

  localparam int unsigned LIT_DEPTH  = 256;
  localparam int unsigned LIT_IDX_W  = 8;
  localparam int unsigned FRAME_W    = 25;
  localparam int unsigned ENC_W      = 26;
  localparam int unsigned BURST_W    = 9;
  localparam int unsigned PACK_IDX_W = 3;
  localparam int unsigned WORD_W     = 8 * BYTES_PER_RESULT;

  typedef struct packed {
    logic [7:0] prev_byte;
    logic [7:0] cur_byte;
    logic       last_in;
  } in_beat_t;

  typedef struct packed {
    logic [WORD_W-1:0] packed_bytes;
    logic [3:0]        byte_count;
    logic              last_of_burst;
    logic              frame_end;
    logic              no_gain;
  } out_beat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRE,
    ST_HDR,
    ST_LIT,
    ST_POST
  } ctrl_state_e;

  typedef enum logic [1:0] {
    SEL_PRE,
    SEL_HDR,
    SEL_LIT,
    SEL_POST
  } byte_sel_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic      load;
    logic      step;
    logic      last_byte;
    byte_sel_e sel;
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic new_pre;
    logic new_lits;
    logic new_post;
    logic lits;
    logic post;
    logic lits_empty;
    logic lit_end;
    logic out_free;
  } dp_sts_t;

endpackage

@@ hw/rtl/fdzre_ctrl.sv @@
// Sequencer that walks one item's emission plan a byte at a time.
module fdzre_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  fdzre_pkg::dp_sts_t sts_i,
  output fdzre_pkg::dp_cmd_t cmd_o
);

  fdzre_pkg::ctrl_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fdzre_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      fdzre_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (sts_i.new_pre) begin
            state_d = fdzre_pkg::ST_PRE;
          end else if (sts_i.new_lits) begin
            state_d = fdzre_pkg::ST_HDR;
          end else if (sts_i.new_post) begin
            state_d = fdzre_pkg::ST_POST;
          end
        end
      end
      fdzre_pkg::ST_PRE: begin
        if (sts_i.out_free) begin
          if (sts_i.lits) begin
            state_d = fdzre_pkg::ST_HDR;
          end else if (sts_i.post) begin
            state_d = fdzre_pkg::ST_POST;
          end else begin
            state_d = fdzre_pkg::ST_IDLE;
          end
        end
      end
      fdzre_pkg::ST_HDR: begin
        if (sts_i.out_free) begin
          if (!sts_i.lits_empty) begin
            state_d = fdzre_pkg::ST_LIT;
          end else if (sts_i.post) begin
            state_d = fdzre_pkg::ST_POST;
          end else begin
            state_d = fdzre_pkg::ST_IDLE;
          end
        end
      end
      fdzre_pkg::ST_LIT: begin
        if (sts_i.out_free && sts_i.lit_end) begin
          state_d = sts_i.post ? fdzre_pkg::ST_POST : fdzre_pkg::ST_IDLE;
        end
      end
      fdzre_pkg::ST_POST: begin
        if (sts_i.out_free) begin
          state_d = fdzre_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = fdzre_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    in_stall_o      = 1'b1;
    cmd_o.load      = 1'b0;
    cmd_o.step      = 1'b0;
    cmd_o.last_byte = 1'b0;
    cmd_o.sel       = fdzre_pkg::SEL_PRE;
    case (state_q)
      fdzre_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      fdzre_pkg::ST_PRE: begin
        cmd_o.sel       = fdzre_pkg::SEL_PRE;
        cmd_o.step      = sts_i.out_free;
        cmd_o.last_byte = !sts_i.lits && !sts_i.post;
      end
      fdzre_pkg::ST_HDR: begin
        cmd_o.sel       = fdzre_pkg::SEL_HDR;
        cmd_o.step      = sts_i.out_free;
        cmd_o.last_byte = sts_i.lits_empty && !sts_i.post;
      end
      fdzre_pkg::ST_LIT: begin
        cmd_o.sel       = fdzre_pkg::SEL_LIT;
        cmd_o.step      = sts_i.out_free;
        cmd_o.last_byte = sts_i.lit_end && !sts_i.post;
      end
      fdzre_pkg::ST_POST: begin
        cmd_o.sel       = fdzre_pkg::SEL_POST;
        cmd_o.step      = sts_i.out_free;
        cmd_o.last_byte = 1'b1;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

endmodule

@@ hw/rtl/fdzre_dpath.sv @@
// Datapath: delta decode, run state, literal buffer, byte packer and result register.
module fdzre_dpath #(
  parameter int unsigned RUN_LIMIT       = fdzre_pkg::RUN_LIMIT_DEF,
  parameter int unsigned MAX_FRAME_BYTES = fdzre_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  fdzre_pkg::in_beat_t  in_beat_i,
  input  fdzre_pkg::dp_cmd_t   cmd_i,
  output fdzre_pkg::dp_sts_t   sts_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output fdzre_pkg::out_beat_t out_beat_o
);

  localparam int unsigned FW = fdzre_pkg::FRAME_W;
  localparam int unsigned EW = fdzre_pkg::ENC_W;
  localparam int unsigned BW = fdzre_pkg::BURST_W;
  localparam int unsigned IW = fdzre_pkg::LIT_IDX_W;
  localparam int unsigned PW = fdzre_pkg::PACK_IDX_W;
  localparam int unsigned WW = fdzre_pkg::WORD_W;

  localparam logic [7:0]    RunLim   = 8'(RUN_LIMIT);
  localparam logic [FW-1:0] FrameMax = FW'(MAX_FRAME_BYTES);
  localparam logic [EW-1:0] EncMax   = '1;
  localparam logic [PW-1:0] PackLast = PW'(fdzre_pkg::BYTES_PER_RESULT - 1);

  // Run state
  logic          iz_q, iz_d;
  logic [7:0]    lc_q, lc_d;
  logic [7:0]    zc_q, zc_d;
  logic [EW-1:0] enc_q, enc_d;
  logic [FW-1:0] frame_q, frame_d;
  logic          frame_last_q;

  // Emission plan of the item in flight
  logic          lits_q, post_q, post_val_q;
  logic [7:0]    pre_val_q, lits_n_q;

  // Plan of the item at the input
  logic          pre_en, lits_en, post_en, post_val, wr_en;
  logic [7:0]    pre_val, lits_n, wr_addr;
  logic [7:0]    delta, lc_inc, zc_inc;
  logic [BW-1:0] burst_len;
  logic [EW:0]   enc_sum;

  // Literal buffer
  logic [7:0]    lit_mem [fdzre_pkg::LIT_DEPTH];
  logic [IW-1:0] lit_idx_q, lit_idx_d;
  logic [7:0]    rdata_q;

  // Packer and result register
  logic [WW-1:0]        pack_q, word;
  logic [PW-1:0]        cnt_q;
  logic [7:0]           cur_out;
  logic                 flush, no_gain;
  logic                 out_valid_q;
  fdzre_pkg::out_beat_t out_beat_q;

  // Decode the item: next run state, buffer write and emission plan
  always_comb begin
    delta    = in_beat_i.prev_byte ^ in_beat_i.cur_byte;
    lc_inc   = lc_q + 8'd1;
    zc_inc   = zc_q + 8'd1;
    pre_en   = 1'b0;
    pre_val  = zc_q;
    lits_en  = 1'b0;
    lits_n   = lc_q;
    post_en  = 1'b0;
    post_val = 1'b0;
    wr_en    = 1'b0;
    wr_addr  = lc_q;
    iz_d     = iz_q;
    lc_d     = lc_q;
    zc_d     = zc_q;
    if (!iz_q) begin
      if (delta != 8'd0) begin
        wr_en = 1'b1;
        lc_d  = lc_inc;
        if (lc_inc >= RunLim) begin
          lits_en = 1'b1;
          lits_n  = lc_inc;
          lc_d    = 8'd0;
          iz_d    = 1'b1;
          zc_d    = 8'd0;
        end
      end else begin
        lits_en = 1'b1;
        lits_n  = lc_q;
        lc_d    = 8'd0;
        iz_d    = 1'b1;
        zc_d    = 8'd1;
        if (RunLim <= 8'd1) begin
          post_en  = 1'b1;
          post_val = 1'b1;
          iz_d     = 1'b0;
          zc_d     = 8'd0;
        end
      end
    end else begin
      if (delta == 8'd0) begin
        zc_d = zc_inc;
        if (zc_inc >= RunLim) begin
          pre_en  = 1'b1;
          pre_val = zc_inc;
          iz_d    = 1'b0;
          zc_d    = 8'd0;
        end
      end else begin
        pre_en  = 1'b1;
        pre_val = zc_q;
        iz_d    = 1'b0;
        zc_d    = 8'd0;
        wr_en   = 1'b1;
        wr_addr = 8'd0;
        lc_d    = 8'd1;
        if (RunLim <= 8'd1) begin
          lits_en = 1'b1;
          lits_n  = 8'd1;
          lc_d    = 8'd0;
          iz_d    = 1'b1;
          zc_d    = 8'd0;
        end
      end
    end
    // Close the open group at frame end
    if (in_beat_i.last_in) begin
      if (iz_d) begin
        if (!pre_en && !lits_en) begin
          pre_en  = 1'b1;
          pre_val = zc_d;
        end else begin
          post_en  = 1'b1;
          post_val = zc_d[0];
        end
      end else if (lc_d != 8'd0) begin
        lits_en  = 1'b1;
        lits_n   = lc_d;
        post_en  = 1'b1;
        post_val = 1'b0;
      end
      iz_d = 1'b0;
      lc_d = 8'd0;
      zc_d = 8'd0;
    end
  end

  // Byte totals for the gain check
  always_comb begin
    burst_len = BW'(pre_en) + BW'(post_en) + (lits_en ? (BW'(lits_n) + BW'(1)) : BW'(0));
    enc_sum   = {1'b0, enc_q} + (EW + 1)'(burst_len);
    enc_d     = enc_sum[EW] ? EncMax : enc_sum[EW-1:0];
    frame_d   = (frame_q < FrameMax) ? (frame_q + FW'(1)) : frame_q;
  end

  // Hold run state and plan
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iz_q         <= 1'b0;
      lc_q         <= 8'd0;
      zc_q         <= 8'd0;
      enc_q        <= '0;
      frame_q      <= '0;
      frame_last_q <= 1'b0;
      lits_q       <= 1'b0;
      post_q       <= 1'b0;
    end else if (cmd_i.load) begin
      iz_q         <= iz_d;
      lc_q         <= lc_d;
      zc_q         <= zc_d;
      enc_q        <= enc_d;
      frame_q      <= frame_d;
      frame_last_q <= in_beat_i.last_in;
      lits_q       <= lits_en;
      post_q       <= post_en;
    end else if (cmd_i.step && cmd_i.last_byte && frame_last_q) begin
      enc_q        <= '0;
      frame_q      <= '0;
      frame_last_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pre_val_q  <= pre_val;
      lits_n_q   <= lits_n;
      post_val_q <= post_val;
    end
  end

  // Literal buffer: write on accept, registered read that tracks the drain index
  always_comb begin
    if (cmd_i.sel == fdzre_pkg::SEL_LIT) begin
      lit_idx_d = cmd_i.step ? (lit_idx_q + IW'(1)) : lit_idx_q;
    end else begin
      lit_idx_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lit_idx_q <= '0;
    end else begin
      lit_idx_q <= lit_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && wr_en) begin
      lit_mem[wr_addr[IW-1:0]] <= delta;
    end
    rdata_q <= lit_mem[lit_idx_d];
  end

  // Pick the byte of the current step and place it into the word
  always_comb begin
    case (cmd_i.sel)
      fdzre_pkg::SEL_PRE:  cur_out = pre_val_q;
      fdzre_pkg::SEL_HDR:  cur_out = lits_n_q;
      fdzre_pkg::SEL_LIT:  cur_out = rdata_q;
      fdzre_pkg::SEL_POST: cur_out = {7'd0, post_val_q};
      default:             cur_out = 8'd0;
    endcase
    word                 = pack_q;
    word[cnt_q * 8 +: 8] = cur_out;
    flush                = cmd_i.last_byte || (cnt_q == PackLast);
    no_gain              = enc_q >= EW'(frame_q);
  end

  // Advance the packer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      pack_q <= '0;
    end else if (cmd_i.step) begin
      if (flush) begin
        cnt_q  <= '0;
        pack_q <= '0;
      end else begin
        cnt_q  <= cnt_q + PW'(1);
        pack_q <= word;
      end
    end
  end

  // Result register: load on a closing byte, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.step && flush) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step && flush) begin
      out_beat_q.packed_bytes  <= word;
      out_beat_q.byte_count    <= 4'(cnt_q) + 4'd1;
      out_beat_q.last_of_burst <= cmd_i.last_byte;
      out_beat_q.frame_end     <= cmd_i.last_byte && frame_last_q;
      out_beat_q.no_gain       <= cmd_i.last_byte && frame_last_q && no_gain;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

  // Status to the controller
  always_comb begin
    sts_o.new_pre    = pre_en;
    sts_o.new_lits   = lits_en;
    sts_o.new_post   = post_en;
    sts_o.lits       = lits_q;
    sts_o.post       = post_q;
    sts_o.lits_empty = (lits_n_q == 8'd0);
    sts_o.lit_end    = (lit_idx_q == (lits_n_q - 8'd1));
    sts_o.out_free   = !out_valid_q || !out_stall_i;
  end

endmodule

@@ hw/rtl/frame_delta_zero_run_encoder.sv @@
// Top level of the frame delta zero-run encoder.
//
// Input channel: one beat per byte position (previous byte, current byte,
// last_in on the final position of a frame). The beat is XORed and folded
// into literal/zero-run groups; literals wait in a 256-entry buffer until
// their count is known.
// Output channel: each beat carries up to 8 encoded bytes, first byte in
// bits 7:0, with byte_count, last_of_burst on the final beat of an item,
// and frame_end/no_gain on the beat that closes a frame.
// Timing: an item that emits nothing leaves the sequencer idle, so such items are
// accepted back to back. An item that emits N bytes holds the input stalled
// while its bytes go out, one byte per cycle through the byte packer while the
// receiver keeps up; a full literal burst plus frame close is at most
// 257 bytes (33 beats). A result beat is registered when the packer's word
// fills or when the last byte of the item is stepped.
// Output stall: the packer and the drain sequencer freeze while the result
// register is full and stalled; nothing is lost.
// Reset: run state, totals and the result register clear; no clearing pass,
// the literal buffer is only read at entries written in the current group.
module frame_delta_zero_run_encoder #(
  parameter int unsigned RUN_LIMIT       = fdzre_pkg::RUN_LIMIT_DEF,
  parameter int unsigned MAX_FRAME_BYTES = fdzre_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  fdzre_pkg::in_beat_t  in_beat_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output fdzre_pkg::out_beat_t out_beat_o
);

  fdzre_pkg::dp_cmd_t cmd;
  fdzre_pkg::dp_sts_t sts;

  fdzre_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fdzre_dpath #(
    .RUN_LIMIT       (RUN_LIMIT),
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_beat_i   (in_beat_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o)
  );

endmodule

@@ hw/rtl/fdzre_checker.sv @@
// Port-level checker for the frame delta zero-run encoder, with its bind.
module fdzre_port_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input fdzre_pkg::in_beat_t  in_beat_i,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input fdzre_pkg::out_beat_t out_beat_o
);

  // Stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_beat_o))
    else $error("stalled result beat changed");

  // Byte count stays within one word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_beat_o.byte_count != 4'd0) && (out_beat_o.byte_count <= 4'd8))
    else $error("byte_count out of range");

  // Only the final beat of a burst is short
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_beat_o.byte_count != 4'd8) |-> out_beat_o.last_of_burst)
    else $error("short beat inside a burst");

  // Frame end closes a burst
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_beat_o.frame_end |-> out_beat_o.last_of_burst)
    else $error("frame_end without last_of_burst");

  // No-gain flag only on the frame-closing beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_beat_o.no_gain |-> out_beat_o.frame_end)
    else $error("no_gain outside frame end");

endmodule

bind frame_delta_zero_run_encoder fdzre_port_checker u_fdzre_checker (.*);

@@ tb/sv/fdzre_checker.sv @@
// Result checker for the frame delta zero-run encoder: predicts the encoded beats and compares.
module fdzre_checker
  import fdzre_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_beat_t  in_beat_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  out_beat_t out_beat_i,
  output int        fail_count_o,
  output int        pending_o,
  output int        beats_checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Encoder state as the predictor keeps it
  logic                 zero_phase;
  logic [LIT_IDX_W-1:0] lit_count;
  logic [7:0]           lit_buf [LIT_DEPTH];
  logic [7:0]           zero_len;
  logic [ENC_W-1:0]     enc_bytes;
  logic [FRAME_W-1:0]   frame_bytes;

  // Bytes caused by the current position
  logic [7:0]           burst [512];
  logic [BURST_W-1:0]   burst_len;

  out_beat_t expected_beats [$];
  int        fail_total;
  int        mismatch_count;
  int        beats_total;

  task automatic clear_run();
    zero_phase  = 1'b0;
    lit_count   = '0;
    zero_len    = '0;
    enc_bytes   = '0;
    frame_bytes = '0;
  endtask

  task automatic push_byte(input logic [7:0] b);
    burst[burst_len] = b;
    burst_len++;
  endtask

  // Emit the literal count, then the buffered literals
  task automatic flush_literals();
    push_byte(lit_count);
    for (int i = 0; i < int'(lit_count); i++) push_byte(lit_buf[i]);
    lit_count = '0;
  endtask

  task automatic add_literal(input logic [7:0] d);
    lit_buf[lit_count] = d;
    lit_count++;
    if (lit_count >= RUN_LIMIT_DEF) begin
      flush_literals();
      zero_phase = 1'b1;
      zero_len   = '0;
    end
  endtask

  task automatic add_zero();
    zero_len++;
    if (zero_len >= RUN_LIMIT_DEF) begin
      push_byte(zero_len);
      zero_phase = 1'b0;
      zero_len   = '0;
    end
  endtask

  // Fold one byte position into the groups and queue the packed beats it causes
  task automatic encode_position(input in_beat_t b);
    logic [7:0] delta;
    logic       grew;
    int         n_words;
    int         cnt;
    out_beat_t  w;

    delta     = b.prev_byte ^ b.cur_byte;
    burst_len = '0;
    if (frame_bytes < MAX_FRAME_BYTES_DEF) frame_bytes++;

    if (!zero_phase) begin
      if (delta != 8'h00) begin
        add_literal(delta);
      end else begin
        flush_literals();
        zero_phase = 1'b1;
        zero_len   = '0;
        add_zero();
      end
    end else begin
      if (delta == 8'h00) begin
        add_zero();
      end else begin
        push_byte(zero_len);
        zero_phase = 1'b0;
        zero_len   = '0;
        add_literal(delta);
      end
    end

    // Close the open group at the end of the frame
    if (b.last_in) begin
      if (zero_phase) begin
        push_byte(zero_len);
      end else if (lit_count > 0) begin
        flush_literals();
        push_byte(8'h00);
      end
    end

    // Saturate the encoded total
    if ({ENC_W{1'b1}} - enc_bytes < ENC_W'(burst_len)) enc_bytes = '1;
    else enc_bytes += ENC_W'(burst_len);
    grew = (enc_bytes >= ENC_W'(frame_bytes));

    n_words = (int'(burst_len) + BYTES_PER_RESULT - 1) / BYTES_PER_RESULT;
    for (int k = 0; k < n_words; k++) begin
      w   = '0;
      cnt = int'(burst_len) - k * BYTES_PER_RESULT;
      if (cnt > BYTES_PER_RESULT) cnt = BYTES_PER_RESULT;
      for (int j = 0; j < cnt; j++) begin
        w.packed_bytes[8*j +: 8] = burst[k * BYTES_PER_RESULT + j];
      end
      w.byte_count    = 4'(cnt);
      w.last_of_burst = (k == n_words - 1);
      w.frame_end     = b.last_in && (k == n_words - 1);
      w.no_gain       = w.frame_end && grew;
      expected_beats.push_back(w);
    end

    if (b.last_in) clear_run();
  endtask

  // Predict on every accepted input beat, compare every accepted output beat
  always @(posedge clk_i or negedge rst_ni) begin
    out_beat_t want;
    if (!rst_ni) begin
      clear_run();
      expected_beats.delete();
      fail_total      = 0;
      mismatch_count  = 0;
      beats_total     = 0;
      fail_count_o    <= 0;
      pending_o       <= 0;
      beats_checked_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) encode_position(in_beat_i);
      if (out_valid_i && !out_stall_i) begin
        beats_total++;
        if (expected_beats.size() == 0) begin
          fail_total++;
          if (mismatch_count < 10) begin
            $display("fdzre_checker: unexpected beat bytes=%h cnt=%0d fe=%b",
                     out_beat_i.packed_bytes, out_beat_i.byte_count,
                     out_beat_i.frame_end);
          end
          mismatch_count++;
        end else begin
          want = expected_beats.pop_front();
          if (out_beat_i.packed_bytes  !== want.packed_bytes  ||
              out_beat_i.byte_count    !== want.byte_count    ||
              out_beat_i.last_of_burst !== want.last_of_burst ||
              out_beat_i.frame_end     !== want.frame_end     ||
              out_beat_i.no_gain       !== want.no_gain) begin
            fail_total++;
            if (mismatch_count < 10) begin
              $display("fdzre_checker: beat %0d exp bytes=%h cnt=%0d lob=%b fe=%b ng=%b",
                       beats_total, want.packed_bytes, want.byte_count,
                       want.last_of_burst, want.frame_end, want.no_gain);
              $display("fdzre_checker: beat %0d got bytes=%h cnt=%0d lob=%b fe=%b ng=%b",
                       beats_total, out_beat_i.packed_bytes, out_beat_i.byte_count,
                       out_beat_i.last_of_burst, out_beat_i.frame_end,
                       out_beat_i.no_gain);
            end
            mismatch_count++;
          end
        end
      end
      fail_count_o    <= fail_total;
      pending_o       <= expected_beats.size();
      beats_checked_o <= beats_total;
    end
  end

endmodule

@@ tb/sv/tb.sv @@
// Testbench top for the frame delta zero-run encoder: clock, reset, stimulus and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fdzre_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 500_000;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_beat_t  in_beat   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_beat;

  int          fail_count;
  int          pending;
  int          beats_checked;
  int          idle_pct  = 0;
  int          stall_pct = 0;
  int          positions = 0;
  int          frames    = 0;
  int unsigned cycle_count = 0;

  frame_delta_zero_run_encoder uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_beat_i   (in_beat),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_beat_o  (out_beat)
  );

  fdzre_checker u_check (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .in_beat_i       (in_beat),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .out_beat_i      (out_beat),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .beats_checked_o (beats_checked)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Stall the result channel at random
  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // Offer one byte position and hold it until the block takes the beat
  task automatic send_item(input logic [7:0] p, input logic [7:0] c, input logic l);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= '{prev_byte: p, cur_byte: c, last_in: l};
    do @(posedge clk); while (in_stall);
    positions++;
    if (l) frames++;
  endtask

  // Send a run of equal (zero delta) or differing (literal) positions
  task automatic send_run(input bit zeros, input int len, input bit close, input bit noisy);
    logic [7:0] p;
    logic [7:0] c;
    for (int i = 0; i < len; i++) begin
      p = 8'($urandom);
      if (noisy && $urandom_range(7) == 0) c = 8'($urandom);
      else if (zeros) c = p;
      else c = p ^ 8'($urandom_range(1, 255));
      send_item(p, c, close && (i == len - 1));
    end
  endtask

  // Frame of alternating short runs
  task automatic send_random_frame();
    int runs;
    int len;
    bit zeros;
    runs  = $urandom_range(1, 4);
    zeros = $urandom_range(1);
    for (int r = 0; r < runs; r++) begin
      case ($urandom_range(9))
        0:       len = 1;
        default: len = $urandom_range(1, 12);
      endcase
      send_run(zeros, len, r == runs - 1, 1'b1);
      zeros = !zeros;
    end
  endtask

  initial begin
    int start;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty literal count, silent positions, byte extremes, frame closes on literal and zero-delta positions
    send_item(8'h00, 8'h00, 1'b0);
    send_item(8'hFF, 8'hFF, 1'b0);
    send_item(8'h00, 8'hFF, 1'b0);
    send_item(8'hFF, 8'h00, 1'b0);
    send_item(8'h55, 8'hAA, 1'b0);
    send_item(8'hAA, 8'h55, 1'b1);
    send_item(8'h12, 8'h34, 1'b1);
    send_item(8'h77, 8'h77, 1'b1);
    send_item(8'h01, 8'h00, 1'b0);
    send_item(8'h80, 8'h80, 1'b1);
    send_item(8'hFE, 8'h01, 1'b0);
    send_item(8'h3C, 8'h3C, 1'b0);
    send_item(8'h3C, 8'h3C, 1'b0);
    send_item(8'h7F, 8'h80, 1'b0);
    send_item(8'h00, 8'h00, 1'b1);

    // Full literal run closing the frame: the longest burst
    stall_pct = 73;
    send_run(1'b0, 255, 1'b1, 1'b0);

    // Random frames across the idle and stall mixes
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 73; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 73; end
        default: begin idle_pct = 7; stall_pct = 7; end
      endcase
      start = positions;
      while (positions - start < 16) send_random_frame();
    end

    // Drain and let any stray beat show up
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("tb: %0d byte positions in %0d frames, %0d result beats checked",
             positions, frames, beats_checked);
    $display("tb: directed closes, a full literal run, four idle/stall mixes");
    if (fail_count == 0 && pending == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
